### sv/bclp_pkg.sv
// ----------------------------------------------------------------------------
// Button click and long-press detector package
// Shared widths, codes and the request and response types of the divider.
// ----------------------------------------------------------------------------
package bclp_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int EVENT_W   = 2;

    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [EVENT_W-1:0]   event_t;

    // Operation codes of an input word.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SKIP   = 1'b1;

    // Result codes.
    localparam event_t EV_NONE   = 2'd0;
    localparam event_t EV_TICK   = 2'd1;
    localparam event_t EV_SINGLE = 2'd2;
    localparam event_t EV_DOUBLE = 2'd3;

    // Configuration register indexes.
    localparam cfg_idx_t REG_DEBOUNCE     = 3'd0;
    localparam cfg_idx_t REG_DOUBLE_CLICK = 3'd1;
    localparam cfg_idx_t REG_LONG_START   = 3'd2;
    localparam cfg_idx_t REG_LONG_STEP    = 3'd3;

    // Register reset values.
    localparam time_t DEBOUNCE_RST     = 32'd30000;
    localparam time_t DOUBLE_CLICK_RST = 32'd300000;
    localparam time_t LONG_START_RST   = 32'd500000;
    localparam time_t LONG_STEP_RST    = 32'd250000;

    typedef struct packed {
        logic  start;
        time_t dividend;
        time_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        time_t quotient;
    } div_resp_t;

endpackage

### sv/bclp_if.sv
// ----------------------------------------------------------------------------
// Button click and long-press detector channels
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface bclp_in_if
    import bclp_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  operation;
    time_t now_time;
    logic  button_level;
    time_t skip_amount;

    modport source (output valid, output operation, output now_time,
                    output button_level, output skip_amount, input ready);
    modport sink   (input valid, input operation, input now_time,
                    input button_level, input skip_amount, output ready);
endinterface

interface bclp_out_if
    import bclp_pkg::*;
();
    logic   valid;
    logic   ready;
    event_t event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

interface bclp_cfg_if
    import bclp_pkg::*;
();
    logic     valid;
    logic     ready;
    cfg_idx_t reg_index;
    time_t    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### sv/bclp_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bclp_div
    import bclp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_resp_t resp
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    time_t            rem_reg, rem_next;
    time_t            quo_reg, quo_next;
    time_t            div_reg, div_next;

    logic [TIME_W:0]  shifted;
    logic [TIME_W:0]  diff;

    assign shifted = {rem_reg, quo_reg[TIME_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            cnt_next  = CNT_W'(TIME_W);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // A clear sign bit means the shifted remainder covers the divisor.
            if (!diff[TIME_W])
            begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

### sv/button_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// Button click and long-press detector
// Debounces one active-low button and reports clicks and long-press ticks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_ch    in         operation, now_time, button_level, skip_amount
//  out_ch   out        event_res, one word per input word
//  cfg      in         reg_index, wr_data (always ready)
//
//  A skip word or a sample that needs no long-press step check loads its
//  result straight after evaluation; a held sample past the first tick first
//  runs the serial divider twice, on the old hold and then on the new one.
//  The input is ready only in the idle state, entered the cycle after a load,
//  and the load waits while the result register is full and not being read.
//  Reset restores the register defaults and clears the button state.
// ----------------------------------------------------------------------------
module button_click_long_press_detector
    import bclp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    bclp_in_if.sink    in_ch,
    bclp_out_if.source out_ch,
    bclp_cfg_if.sink   cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_DIV_A = 5'b00100,
        S_DIV_B = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t    state_reg, state_next;

    time_t     debounce_reg, dcw_reg, lps_reg, step_reg;

    logic      is_pressed_reg, is_pressed_next;
    time_t     press_start_reg, press_start_next;
    time_t     click_time_reg, click_time_next;
    time_t     deb_start_reg, deb_start_next;
    time_t     held_reg, held_next;

    logic      op_reg, level_reg;
    time_t     now_reg, amount_reg;
    event_t    ev_reg, ev_next;
    time_t     qa_reg, qa_next;

    logic      out_valid_reg, out_valid_next;
    event_t    out_ev_reg, out_ev_next;

    div_req_t  div_req;
    div_resp_t div_resp;

    time_t     since_deb, since_press, since_click, step_eff;
    logic      load_out;

    bclp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            dcw_reg      <= DOUBLE_CLICK_RST;
            lps_reg      <= LONG_START_RST;
            step_reg     <= LONG_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_DEBOUNCE:     debounce_reg <= cfg.wr_data;
                REG_DOUBLE_CLICK: dcw_reg      <= cfg.wr_data;
                REG_LONG_START:   lps_reg      <= cfg.wr_data;
                REG_LONG_STEP:    step_reg     <= cfg.wr_data;
                default:          ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg     <= in_ch.operation;
            now_reg    <= in_ch.now_time;
            level_reg  <= in_ch.button_level;
            amount_reg <= in_ch.skip_amount;
        end
    end

    assign since_deb   = now_reg - deb_start_reg;
    assign since_press = now_reg - press_start_reg;
    assign since_click = now_reg - click_time_reg;
    assign step_eff    = (step_reg != '0) ? step_reg : TIME_W'(1);
    assign load_out    = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next       = state_reg;
        is_pressed_next  = is_pressed_reg;
        press_start_next = press_start_reg;
        click_time_next  = click_time_reg;
        deb_start_next   = deb_start_reg;
        held_next        = held_reg;
        ev_next          = ev_reg;
        qa_next          = qa_reg;
        div_req.start    = 1'b0;
        div_req.dividend = held_reg - lps_reg;
        div_req.divisor  = step_eff;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                ev_next    = EV_NONE;
                state_next = S_DONE;
                if (op_reg == OP_SKIP)
                begin
                    // Unset timestamps stay at zero.
                    if (press_start_reg != '0) press_start_next = press_start_reg + amount_reg;
                    if (click_time_reg != '0)  click_time_next  = click_time_reg + amount_reg;
                    if (deb_start_reg != '0)   deb_start_next   = deb_start_reg + amount_reg;
                    if (held_reg != '0)        held_next        = held_reg + amount_reg;
                end
                else if (since_deb <= debounce_reg)
                begin
                    ev_next = EV_NONE;
                end
                else if (!level_reg)
                begin
                    if (!is_pressed_reg)
                    begin
                        deb_start_next   = now_reg;
                        press_start_next = now_reg;
                        held_next        = '0;
                        is_pressed_next  = 1'b1;
                    end
                    else if (since_press > lps_reg)
                    begin
                        held_next = since_press;
                        if (held_reg == '0)
                        begin
                            click_time_next = '0;
                            ev_next         = EV_TICK;
                        end
                        else
                        begin
                            // Divide the previous hold first; the new one follows.
                            div_req.start = 1'b1;
                            state_next    = S_DIV_A;
                        end
                    end
                end
                else if (click_time_reg != '0 && since_click > dcw_reg)
                begin
                    click_time_next = '0;
                    is_pressed_next = 1'b0;
                    ev_next         = EV_SINGLE;
                end
                else if (is_pressed_reg)
                begin
                    is_pressed_next = 1'b0;
                    deb_start_next  = now_reg;
                    if (click_time_reg != '0)
                    begin
                        press_start_next = '0;
                        click_time_next  = '0;
                        ev_next          = EV_DOUBLE;
                    end
                    else if (held_reg >= lps_reg)
                    begin
                        held_next        = '0;
                        press_start_next = '0;
                        click_time_next  = '0;
                    end
                    else
                    begin
                        click_time_next = now_reg;
                    end
                end
            end

            S_DIV_A:
            begin
                if (div_resp.done)
                begin
                    qa_next       = div_resp.quotient;
                    div_req.start = 1'b1;
                    state_next    = S_DIV_B;
                end
            end

            S_DIV_B:
            begin
                if (div_resp.done)
                begin
                    state_next = S_DONE;
                    if (qa_reg != div_resp.quotient)
                    begin
                        click_time_next = '0;
                        ev_next         = EV_TICK;
                    end
                end
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_ev_next    = ev_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            is_pressed_reg  <= 1'b0;
            press_start_reg <= '0;
            click_time_reg  <= '0;
            deb_start_reg   <= '0;
            held_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            is_pressed_reg  <= is_pressed_next;
            press_start_reg <= press_start_next;
            click_time_reg  <= click_time_next;
            deb_start_reg   <= deb_start_next;
            held_reg        <= held_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg     <= ev_next;
        qa_reg     <= qa_next;
        out_ev_reg <= out_ev_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.event_res = out_ev_reg;

    // The divider only finishes while the sequencer waits on it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> (state_reg == S_DIV_A || state_reg == S_DIV_B))
        else $error("divider finished outside a wait state");

    // An accepted word is evaluated in the next cycle.
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg == S_EVAL))
        else $error("accepted word not evaluated");

    // A long-press tick always drops a recorded click.
    a_tick_clears_click: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && ev_reg == EV_TICK) |-> (click_time_reg == '0))
        else $error("tick left a click recorded");

endmodule
